// ===== src/tcce_pkg.sv =====
// Shared widths, codes and the cell layout of the text console cell engine.
package tcce_pkg;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 64;

	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int COLOUR_W   = 8;
	localparam int RD_ROW_W   = 6;
	localparam int RD_COL_W   = 7;
	localparam int CUR_COL_W  = 7;
	localparam int CUR_ROW_W  = 6;
	localparam int COLS_REG_W = 8;
	localparam int ROWS_REG_W = 7;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CELL_W     = 32;

	localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd60;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS = 1'b0,
		REG_ROWS    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CHAR_W-1:0]   chr;
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
	} cell_t;

endpackage

// ===== src/tcce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/text_console_cell_engine.sv =====
// A put without scroll, an unused command and an off-screen read answer straight from
// S_IDLE; an on-screen read answers through S_READ. A scroll moves each row in use up at
// MAX_COLS pitch, then blanks the bottom row, one cell at a time through the single RAM
// write port. Clear zeroes every cell of the padded store. Puts without scroll sustain one
// per cycle while rsp_ready is high. Reset: async, active low; afterwards a sweep zeroes
// every cell with req_ready low; configuration writes are taken throughout.
module text_console_cell_engine #(
	parameter int MAX_COLS = tcce_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tcce_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [tcce_pkg::CMD_W-1:0]      command,
	input  logic [tcce_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcce_pkg::COLOUR_W-1:0]   red,
	input  logic [tcce_pkg::COLOUR_W-1:0]   green,
	input  logic [tcce_pkg::COLOUR_W-1:0]   blue,
	input  logic [tcce_pkg::RD_ROW_W-1:0]   read_row,
	input  logic [tcce_pkg::RD_COL_W-1:0]   read_col,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [tcce_pkg::CUR_COL_W-1:0]  cursor_col,
	output logic [tcce_pkg::CUR_ROW_W-1:0]  cursor_row,
	output logic [tcce_pkg::CHAR_W-1:0]     cell_char,
	output logic [tcce_pkg::COLOUR_W-1:0]   cell_red,
	output logic [tcce_pkg::COLOUR_W-1:0]   cell_green,
	output logic [tcce_pkg::COLOUR_W-1:0]   cell_blue,
	output logic                            scrolled
);

	import tcce_pkg::*;

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNW   = $clog2(MAX_COLS + 1);
	localparam int RNW   = $clog2(MAX_ROWS + 1);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 2 ** AW;

	localparam logic [CNW-1:0] COLS_MAX  = CNW'(MAX_COLS);
	localparam logic [RNW-1:0] ROWS_MAX  = RNW'(MAX_ROWS);
	localparam logic [CW-1:0]  COL_LAST  = CW'(MAX_COLS - 1);
	localparam logic [AW-1:0]  ADDR_LAST = AW'(DEPTH - 1);

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_CLEAR = 6'b000100,
		S_READ  = 6'b001000,
		S_COPY  = 6'b010000,
		S_LAST  = 6'b100000
	} state_t;

	state_t                state_q;
	logic [COLS_REG_W-1:0] cols_q;
	logic [ROWS_REG_W-1:0] rows_q;
	logic [CW-1:0]         cursor_col_q;
	logic [RW-1:0]         cursor_row_q;
	logic [AW-1:0]         sw_q;
	logic [RW-1:0]         cp_row_q;
	logic [CW-1:0]         cp_col_q;
	logic                  cp_valid_s1;
	logic [AW-1:0]         cp_addr_s1;
	logic                  rsp_valid_q;
	cell_t                 cell_q;
	logic                  scrolled_q;

	logic [CNW-1:0] cols_eff;
	logic [RNW-1:0] rows_eff;
	logic [CW-1:0]  col_c;
	logic [RW-1:0]  row_c;
	logic [CW-1:0]  col_n;
	logic [RNW-1:0] row_n;
	logic           put_write;
	logic           put_scroll;
	logic           rd_hit;
	logic           req_fire;
	logic [RW-1:0]  last_row;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Registers are used clamped to 1..MAX
	always_comb begin
		if (cols_q == '0) begin
			cols_eff = CNW'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			cols_eff = COLS_MAX;
		end else begin
			cols_eff = CNW'(cols_q);
		end
		if (rows_q == '0) begin
			rows_eff = RNW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			rows_eff = ROWS_MAX;
		end else begin
			rows_eff = RNW'(rows_q);
		end
	end

	assign last_row = RW'(rows_eff - RNW'(1));

	// Cursor step for a put
	always_comb begin
		col_c = cursor_col_q;
		row_c = cursor_row_q;
		if (CNW'(cursor_col_q) >= cols_eff) begin
			col_c = CW'(cols_eff - CNW'(1));
		end
		if (RNW'(cursor_row_q) >= rows_eff) begin
			row_c = last_row;
		end
		put_write = 1'b0;
		col_n = col_c;
		row_n = RNW'(row_c);
		if (char_code == CH_NEWLINE) begin
			col_n = '0;
			row_n = RNW'(row_c) + RNW'(1);
		end else if (char_code == CH_BACKSPACE) begin
			if (col_c != '0) begin
				col_n = col_c - CW'(1);
			end else if (row_c != '0) begin
				col_n = CW'(cols_eff - CNW'(1));
				row_n = RNW'(row_c) - RNW'(1);
			end
		end else begin
			put_write = 1'b1;
			if (CNW'(col_c) + CNW'(1) >= cols_eff) begin
				col_n = '0;
				row_n = RNW'(row_c) + RNW'(1);
			end else begin
				col_n = col_c + CW'(1);
			end
		end
		put_scroll = (row_n >= rows_eff);
	end

	assign rd_hit    = (read_row < rows_eff) && (read_col < cols_eff);
	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sw_q;
		ram_wdata = '0;
		ram_raddr = {RW'(read_row), CW'(read_col)};
		case (state_q)
			S_INIT, S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_we    = req_fire && (command == CMD_PUT) && put_write;
				ram_waddr = {row_c, col_c};
				ram_wdata = {char_code, red, green, blue};
			end
			S_COPY: begin
				ram_raddr = {cp_row_q + RW'(1), cp_col_q};
				ram_we    = cp_valid_s1;
				ram_waddr = cp_addr_s1;
				ram_wdata = ram_rdata;
			end
			S_LAST: begin
				// drain the last copied cell before clearing the bottom row
				if (cp_valid_s1) begin
					ram_we    = 1'b1;
					ram_waddr = cp_addr_s1;
					ram_wdata = ram_rdata;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = {last_row, cp_col_q};
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tcce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLUMNS: cols_q <= COLS_REG_W'(cfg_data);
				REG_ROWS:    rows_q <= ROWS_REG_W'(cfg_data);
				default:     ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			sw_q         <= '0;
			cp_row_q     <= '0;
			cp_col_q     <= '0;
			cp_valid_s1  <= 1'b0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			cp_valid_s1 <= (state_q == S_COPY);
			case (state_q)
				S_INIT: begin
					sw_q <= sw_q + AW'(1);
					if (sw_q == ADDR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						case (command)
							CMD_PUT: begin
								cursor_col_q <= col_n;
								if (put_scroll) begin
									cursor_row_q <= last_row;
									cp_row_q     <= '0;
									cp_col_q     <= '0;
									state_q      <= (rows_eff > RNW'(1)) ? S_COPY : S_LAST;
								end else begin
									cursor_row_q <= RW'(row_n);
									rsp_valid_q  <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								cursor_col_q <= '0;
								cursor_row_q <= '0;
								sw_q         <= '0;
								state_q      <= S_CLEAR;
							end
							CMD_READ: begin
								if (rd_hit) begin
									state_q <= S_READ;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_CLEAR: begin
					sw_q <= sw_q + AW'(1);
					if (sw_q == ADDR_LAST) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
					end
				end
				S_READ: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
				S_COPY: begin
					if (cp_col_q == COL_LAST) begin
						cp_col_q <= '0;
						if (RNW'(cp_row_q) + RNW'(2) == rows_eff) begin
							state_q <= S_LAST;
						end else begin
							cp_row_q <= cp_row_q + RW'(1);
						end
					end else begin
						cp_col_q <= cp_col_q + CW'(1);
					end
				end
				S_LAST: begin
					if (!cp_valid_s1) begin
						if (cp_col_q == COL_LAST) begin
							state_q     <= S_IDLE;
							rsp_valid_q <= 1'b1;
						end else begin
							cp_col_q <= cp_col_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= {cp_row_q, cp_col_q};
		if (req_fire) begin
			cell_q     <= '0;
			scrolled_q <= (command == CMD_PUT) && put_scroll;
		end else if (state_q == S_READ) begin
			cell_q <= ram_rdata;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign cursor_col = CUR_COL_W'(cursor_col_q);
	assign cursor_row = CUR_ROW_W'(cursor_row_q);
	assign cell_char  = cell_q.chr;
	assign cell_red   = cell_q.red;
	assign cell_green = cell_q.green;
	assign cell_blue  = cell_q.blue;
	assign scrolled   = scrolled_q;

`ifndef NO_ASSERTIONS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |-> !req_ready)
		else $error("request taken while a result is held");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && scrolled_q |-> cursor_row_q == last_row)
		else $error("scrolled result with cursor off the last row");

	a_copy_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> (state_q == S_COPY || state_q == S_LAST))
		else $error("copy write outside the scroll sequence");

	a_put_done: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && command == CMD_PUT && !put_scroll |=> rsp_valid_q && state_q == S_IDLE)
		else $error("plain put did not finish in one cycle");
`endif

endmodule

// ===== test/tb_text_console_cell_engine.sv =====
// Self-checking testbench for the text console cell engine: directed table, then random phases.
`timescale 1ns / 1ps

module tb_text_console_cell_engine;
	import tcce_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int GRID_COLS      = MAX_COLS_DEF;
	localparam int GRID_ROWS      = MAX_ROWS_DEF;
	localparam int RANDOM_ITEMS   = 820;
	localparam int CALM_ITEMS     = 100;
	localparam int SQUEEZE_CYCLES = 600;
	// short quiet gap before the registers change
	localparam int SETTLE_CYCLES  = 16;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [CHAR_W-1:0]   chr;
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
		logic [RD_ROW_W-1:0] rrow;
		logic [RD_COL_W-1:0] rcol;
	} console_req_t;

	typedef struct packed {
		logic [CUR_COL_W-1:0] ccol;
		logic [CUR_ROW_W-1:0] crow;
		logic [CHAR_W-1:0]    chr;
		logic [COLOUR_W-1:0]  red;
		logic [COLOUR_W-1:0]  green;
		logic [COLOUR_W-1:0]  blue;
		logic                 scroll;
	} console_rsp_t;

	typedef struct packed {
		bit           cfg_step;
		logic [7:0]   cols_val;
		logic [7:0]   rows_val;
		console_req_t req;
		bit           typed;
		console_rsp_t rsp;
	} stim_row_t;

	localparam console_req_t NO_REQ = '0;
	localparam console_rsp_t NO_RSP = '0;

	localparam logic [7:0] COL_EXTREMES [4] = '{8'd0, 8'd1, 8'd128, 8'd255};
	localparam logic [7:0] ROW_EXTREMES [5] = '{8'd0, 8'd1, 8'd64, 8'd128, 8'd255};

	localparam stim_row_t DIRECTED [30] = '{
		// straight after reset: 80 x 60
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd63, 7'd127},
			1'b1, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd63, 7'd127},
			1'b1, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, CH_BACKSPACE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd0, 7'd0},
			1'b1, '{7'd1, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, '{7'd1, 6'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, '{7'd2, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, '{7'd0, 6'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		// backspace from column 0 wraps to the end of the row above
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, CH_BACKSPACE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, '{7'd79, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, '{CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b1, NO_RSP},
		// 3 x 2: wrap, scroll on the last cell, reads in and out of range
		'{1'b1, 8'd3, 8'd2, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h41, 8'h12, 8'h34, 8'h56, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h42, 8'hAA, 8'h55, 8'h0F, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h43, 8'h01, 8'h80, 8'hFE, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h44, 8'h7F, 8'hF0, 8'h3C, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h45, 8'hC3, 8'h96, 8'h69, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h46, 8'h11, 8'h22, 8'h33, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd1, 7'd2}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd2, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b0, NO_RSP},
		// zero registers clamp to 1 x 1, cursor left outside the shrunken screen
		'{1'b1, 8'd0, 8'd0, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h58, 8'h01, 8'h02, 8'h03, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, CH_BACKSPACE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0},
			1'b0, NO_RSP},
		// all-ones registers clamp to the full 128 x 64
		'{1'b1, 8'd255, 8'd255, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_PUT, 8'h7E, 8'h5A, 8'hA5, 8'hFF, 6'd0, 7'd0}, 1'b0, NO_RSP},
		'{1'b0, 8'd0, 8'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd63, 7'd127},
			1'b0, NO_RSP}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_ready;
	logic [CMD_W-1:0]      command;
	logic [CHAR_W-1:0]     char_code;
	logic [COLOUR_W-1:0]   red;
	logic [COLOUR_W-1:0]   green;
	logic [COLOUR_W-1:0]   blue;
	logic [RD_ROW_W-1:0]   read_row;
	logic [RD_COL_W-1:0]   read_col;
	logic                  rsp_valid;
	logic                  rsp_ready;
	logic [CUR_COL_W-1:0]  cursor_col;
	logic [CUR_ROW_W-1:0]  cursor_row;
	logic [CHAR_W-1:0]     cell_char;
	logic [COLOUR_W-1:0]   cell_red;
	logic [COLOUR_W-1:0]   cell_green;
	logic [COLOUR_W-1:0]   cell_blue;
	logic                  scrolled;

	// shadow of the console
	cell_t                 screen [GRID_ROWS * GRID_COLS];
	int                    cursor_x;
	int                    cursor_y;
	logic [COLS_REG_W-1:0] cols_reg;
	logic [ROWS_REG_W-1:0] rows_reg;

	console_rsp_t    pending_replies [$];
	int              mismatch_count;
	int              reply_count;
	int              items_sent;
	longint unsigned cycle_count;
	longint unsigned cycle_allowance;
	bit              calm;
	bit              quiet_phase;
	bit              squeeze_now;

	text_console_cell_engine u_dut (.*);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int effective(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic console_rsp_t advance_console(console_req_t rq);
		int           cols;
		int           rows;
		int           col;
		int           row;
		cell_t        rd;
		console_rsp_t rs;
		cols = effective(int'(cols_reg), GRID_COLS);
		rows = effective(int'(rows_reg), GRID_ROWS);
		rd = '0;
		rs = '0;
		if (rq.cmd == CMD_PUT) begin
			col = (cursor_x >= cols) ? cols - 1 : cursor_x;
			row = (cursor_y >= rows) ? rows - 1 : cursor_y;
			if (rq.chr == CH_NEWLINE) begin
				col = 0;
				row++;
			end else if (rq.chr == CH_BACKSPACE) begin
				if (col > 0) begin
					col--;
				end else if (row > 0) begin
					col = cols - 1;
					row--;
				end
			end else begin
				screen[row * GRID_COLS + col] = {rq.chr, rq.red, rq.green, rq.blue};
				col++;
				if (col >= cols) begin
					col = 0;
					row++;
				end
			end
			if (row >= rows) begin
				// whole rows at fixed pitch move up, last row in use blanked
				for (int i = 0; i < (rows - 1) * GRID_COLS; i++)
					screen[i] = screen[i + GRID_COLS];
				for (int i = 0; i < GRID_COLS; i++)
					screen[(rows - 1) * GRID_COLS + i] = '0;
				row = rows - 1;
				rs.scroll = 1'b1;
			end
			cursor_x = col;
			cursor_y = row;
		end else if (rq.cmd == CMD_CLEAR) begin
			foreach (screen[i])
				screen[i] = '0;
			cursor_x = 0;
			cursor_y = 0;
		end else if (rq.cmd == CMD_READ) begin
			if (int'(rq.rrow) < rows && int'(rq.rcol) < cols)
				rd = screen[int'(rq.rrow) * GRID_COLS + int'(rq.rcol)];
		end
		rs.ccol  = cursor_x[CUR_COL_W-1:0];
		rs.crow  = cursor_y[CUR_ROW_W-1:0];
		rs.chr   = rd.chr;
		rs.red   = rd.red;
		rs.green = rd.green;
		rs.blue  = rd.blue;
		return rs;
	endfunction

	function automatic console_req_t random_request();
		console_req_t rq;
		int           cols;
		int           rows;
		int           pick;
		cols = effective(int'(cols_reg), GRID_COLS);
		rows = effective(int'(rows_reg), GRID_ROWS);
		rq.cmd   = CMD_PUT;
		rq.chr   = 8'($urandom_range(0, 255));
		rq.red   = 8'($urandom_range(0, 255));
		rq.green = 8'($urandom_range(0, 255));
		rq.blue  = 8'($urandom_range(0, 255));
		rq.rrow  = 6'($urandom_range(0, 63));
		rq.rcol  = 7'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if (pick < 1) begin
			rq.cmd = CMD_CLEAR;
		end else if (pick < 4) begin
			rq.cmd = CMD_UNUSED;
		end else if (pick < 28) begin
			rq.cmd = CMD_READ;
			// mostly on screen, some anywhere
			if ($urandom_range(0, 4) != 0) begin
				rq.rrow = 6'($urandom_range(0, rows - 1));
				rq.rcol = 7'($urandom_range(0, cols - 1));
			end
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 14)
				rq.chr = CH_NEWLINE;
			else if (pick < 22)
				rq.chr = CH_BACKSPACE;
			else if (pick < 25)
				rq.chr = '0;
		end
		return rq;
	endfunction

	task automatic compare_field(string name, int got, int want);
		if (got != want) begin
			mismatch_count++;
			$display("reply %0d: %s is %0h, expected %0h", reply_count, name, got, want);
		end
	endtask

	// sender sits at a rising edge on entry and on return
	task automatic send_request(console_req_t rq, bit typed, console_rsp_t typed_rsp);
		console_rsp_t predicted;
		int           rows;
		rows = effective(int'(rows_reg), GRID_ROWS);
		if (rq.cmd == CMD_CLEAR)
			cycle_allowance += 40 + 8200;
		else if (rq.cmd == CMD_PUT)
			cycle_allowance += 40 + rows * GRID_COLS + 8;
		else
			cycle_allowance += 44;
		req_valid <= 1'b1;
		command   <= rq.cmd;
		char_code <= rq.chr;
		red       <= rq.red;
		green     <= rq.green;
		blue      <= rq.blue;
		read_row  <= rq.rrow;
		read_col  <= rq.rcol;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = advance_console(rq);
		pending_replies.push_back(typed ? typed_rsp : predicted);
		items_sent++;
	endtask

	task automatic settle_and_configure(logic [7:0] cols_val, logic [7:0] rows_val);
		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cycle_allowance += SETTLE_CYCLES + 16;
		cfg_we    <= 1'b1;
		cfg_index <= REG_COLUMNS;
		cfg_data  <= cols_val;
		@(posedge clk);
		cols_reg = cols_val;
		cfg_index <= REG_ROWS;
		cfg_data  <= rows_val;
		@(posedge clk);
		rows_reg = rows_val[ROWS_REG_W-1:0];
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4 * cycle_allowance) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin : reply_check
		console_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_replies.size() == 0) begin
				compare_field("reply with no request outstanding", 1, 0);
			end else begin
				want = pending_replies.pop_front();
				compare_field("cursor_col", int'(cursor_col), int'(want.ccol));
				compare_field("cursor_row", int'(cursor_row), int'(want.crow));
				compare_field("cell_char", int'(cell_char), int'(want.chr));
				compare_field("cell_red", int'(cell_red), int'(want.red));
				compare_field("cell_green", int'(cell_green), int'(want.green));
				compare_field("cell_blue", int'(cell_blue), int'(want.blue));
				compare_field("scrolled", int'(scrolled), int'(want.scroll));
			end
			reply_count++;
		end
	end

	initial begin : reply_sink
		bit squeezed;
		squeezed = 1'b0;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_now && !squeezed) begin
				// long hold-off so the engine backs up and stalls requests
				squeezed = 1'b1;
				rsp_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES)
					@(posedge clk);
			end else if (!calm && !quiet_phase && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 14))
					@(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int         random_sent;
		int         phase_len;
		int         pick;
		logic [7:0] cols_val;
		logic [7:0] rows_val;
		foreach (screen[i])
			screen[i] = '0;
		cursor_x        = 0;
		cursor_y        = 0;
		cols_reg        = COLS_RESET;
		rows_reg        = ROWS_RESET;
		mismatch_count  = 0;
		reply_count     = 0;
		items_sent      = 0;
		cycle_count     = 0;
		cycle_allowance = 20000;
		calm            = 1'b0;
		quiet_phase     = 1'b1;
		squeeze_now     = 1'b0;
		random_sent     = 0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data  = '0;
		req_valid = 1'b0;
		command   = CMD_PUT;
		char_code = '0;
		red       = '0;
		green     = '0;
		blue      = '0;
		read_row  = '0;
		read_col  = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].cfg_step)
				settle_and_configure(DIRECTED[i].cols_val, DIRECTED[i].rows_val);
			else
				send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].rsp);
		end

		while (random_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// small screens make wraps and scrolls frequent
				cols_val = 8'($urandom_range(1, 12));
				rows_val = 8'($urandom_range(1, 6));
			end else if (pick == 6) begin
				cols_val = COL_EXTREMES[$urandom_range(0, 3)];
				rows_val = ROW_EXTREMES[$urandom_range(0, 4)];
			end else if (pick < 9) begin
				cols_val = 8'($urandom_range(0, 255));
				rows_val = 8'($urandom_range(1, 8));
			end else begin
				cols_val = 8'($urandom_range(1, 16));
				rows_val = 8'($urandom_range(0, 255));
			end
			settle_and_configure(cols_val, rows_val);
			quiet_phase = ($urandom_range(0, 2) == 0);
			phase_len = $urandom_range(40, 90);
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
				if (!squeeze_now && random_sent >= 350 && k == 5)
					squeeze_now = 1'b1;
				if (!calm && !quiet_phase && $urandom_range(0, 3) == 0) begin
					req_valid <= 1'b0;
					repeat ($urandom_range(1, 14))
						@(posedge clk);
				end
				send_request(random_request(), 1'b0, NO_RSP);
				random_sent++;
			end
		end

		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (64)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
